/* hw/rtl/msid_pkg.sv */
// Shared types and constants for the multichannel spike interval detector.
// Used by multichannel_spike_interval_detector_core and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msid_pkg;

  localparam int CHANNELS = 64;
  localparam int CH_W     = 6;
  localparam int SAMPLE_W = 16;
  localparam int TS_W     = 32;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_UP_THRESHOLD   = 1'b0;
  localparam logic REG_DOWN_THRESHOLD = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] UP_THRESHOLD_RESET   = 16'sd16384;
  localparam logic signed [SAMPLE_W-1:0] DOWN_THRESHOLD_RESET = 16'sd0;

  // One entry of the per-channel state memory.
  typedef struct packed {
    logic            spiking;
    logic [TS_W-1:0] last_ts;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/msid_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic                         re,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output      logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to the same address in one cycle return old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/multichannel_spike_interval_detector_core.sv */
// Multichannel spike interval detector, top level.
// Depends on msid_pkg and msid_ram.
//
// Usage:
//   Input requests (in_channel, in_sample, in_timestamp) arrive on a valid/ready
//   channel, one channel sample per request. Each channel has a hysteresis flag:
//   a sample above the upper threshold sets it, one below the lower threshold
//   clears it. When a flag goes from clear to set, one result request
//   (out_spike_channel, out_interval) is issued, with the interval measured from
//   that channel's previous spike time modulo 2^32.
//   A spike result is formed in the read stage, then held in the output register.
//   Throughput: one request per cycle while results are taken. Per-channel state
//   lives in one memory, read at the acceptance edge and written back as the
//   request leaves stage 1; a bypass register covers back-to-back requests on one channel.
//   Reset: thresholds return to 16384 and 0; per-channel valid flops clear at
//   once, so every channel reads as not spiking with last spike time zero. No
//   clearing pass is needed; requests are taken from the first cycle.
//   Stall: a held result stays in the output register; one further request is
//   taken into the read stage and waits there, and in_ready drops until the
//   receiver takes the result.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_spike_interval_detector_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Input channel
  input  wire logic                                   in_valid,
  output      logic                                   in_ready,
  input  wire logic [msid_pkg::CH_W-1:0]              in_channel,
  input  wire logic signed [msid_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic [msid_pkg::TS_W-1:0]              in_timestamp,
  // Result channel
  output      logic                                   out_valid,
  input  wire logic                                   out_ready,
  output      logic [msid_pkg::CH_W-1:0]              out_spike_channel,
  output      logic [msid_pkg::TS_W-1:0]              out_interval,
  // Configuration port
  input  wire logic                                   cfg_psel,
  input  wire logic                                   cfg_penable,
  input  wire logic                                   cfg_pwrite,
  input  wire logic [msid_pkg::CFG_AW-1:0]            cfg_paddr,
  input  wire logic [msid_pkg::CFG_DW-1:0]            cfg_pwdata,
  output      logic [msid_pkg::CFG_DW-1:0]            cfg_prdata,
  output      logic                                   cfg_pready
);

  // Configuration registers
  logic signed [msid_pkg::SAMPLE_W-1:0] up_thr_r;
  logic signed [msid_pkg::SAMPLE_W-1:0] down_thr_r;
  logic                                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_thr_r   <= msid_pkg::UP_THRESHOLD_RESET;
      down_thr_r <= msid_pkg::DOWN_THRESHOLD_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        msid_pkg::REG_UP_THRESHOLD:   up_thr_r   <= cfg_pwdata[msid_pkg::SAMPLE_W-1:0];
        msid_pkg::REG_DOWN_THRESHOLD: down_thr_r <= cfg_pwdata[msid_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      msid_pkg::REG_UP_THRESHOLD:
        cfg_prdata = {{(msid_pkg::CFG_DW-msid_pkg::SAMPLE_W){up_thr_r[msid_pkg::SAMPLE_W-1]}},
                      up_thr_r};
      msid_pkg::REG_DOWN_THRESHOLD:
        cfg_prdata = {{(msid_pkg::CFG_DW-msid_pkg::SAMPLE_W){down_thr_r[msid_pkg::SAMPLE_W-1]}},
                      down_thr_r};
      default: cfg_prdata = '0;
    endcase
  end

  // Pipeline control
  logic                                 in_fire;
  logic                                 s1_go;
  logic                                 s1_valid_r;
  logic [msid_pkg::CH_W-1:0]            s1_ch_r;
  logic signed [msid_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic [msid_pkg::TS_W-1:0]            s1_ts_r;
  logic                                 s1_entry_vld_r;
  logic                                 fwd_hit_r;
  msid_pkg::entry_t                     fwd_data_r;
  logic [msid_pkg::CHANNELS-1:0]        entry_vld_r;

  logic                                 out_valid_r;
  logic [msid_pkg::CH_W-1:0]            out_ch_r;
  logic [msid_pkg::TS_W-1:0]            out_interval_r;

  logic [$bits(msid_pkg::entry_t)-1:0]  ram_rdata;
  msid_pkg::entry_t                     prev;
  msid_pkg::entry_t                     wr_entry;
  logic                                 in_range;
  logic                                 above;
  logic                                 below;
  logic                                 spike;
  logic                                 wr_en;
  logic                                 emit;
  logic [msid_pkg::TS_W-1:0]            interval;

  assign s1_go    = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  // Read-modify-write of the channel entry in stage 1.
  always_comb begin
    if (fwd_hit_r) begin
      prev = fwd_data_r;
    end else if (s1_entry_vld_r) begin
      prev = msid_pkg::entry_t'(ram_rdata);
    end else begin
      prev = '0;
    end
    in_range = {1'b0, s1_ch_r} < (msid_pkg::CH_W+1)'(msid_pkg::CHANNELS);
    above    = s1_sample_r > up_thr_r;
    below    = s1_sample_r < down_thr_r;
    spike    = above && !prev.spiking;
    interval = s1_ts_r - prev.last_ts;

    wr_entry = prev;
    if (above) begin
      wr_entry.spiking = 1'b1;
    end else if (below) begin
      wr_entry.spiking = 1'b0;
    end
    if (spike) begin
      wr_entry.last_ts = s1_ts_r;
    end

    wr_en = s1_valid_r && s1_go && in_range;
    emit  = wr_en && spike;
  end

  msid_ram #(
    .WIDTH ($bits(msid_pkg::entry_t)),
    .DEPTH (msid_pkg::CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_ch_r),
    .wdata (wr_entry),
    .re    (in_fire),
    .raddr (in_channel),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      entry_vld_r <= '0;
      fwd_hit_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end

      if (wr_en) begin
        entry_vld_r[s1_ch_r] <= 1'b1;
      end

      // The memory returns old data when the write lands on the edge of the read.
      if (in_fire) begin
        fwd_hit_r <= wr_en && (s1_ch_r == in_channel);
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r        <= in_channel;
      s1_sample_r    <= in_sample;
      s1_ts_r        <= in_timestamp;
      s1_entry_vld_r <= entry_vld_r[in_channel];
      fwd_data_r     <= wr_entry;
    end
    if (emit) begin
      out_ch_r       <= s1_ch_r;
      out_interval_r <= interval;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_spike_channel = out_ch_r;
  assign out_interval      = out_interval_r;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for multichannel_spike_interval_detector_core.
// Needs msid_pkg and the core RTL. Drives samples and threshold writes, predicts
// the spike requests and compares them with the block's result port.
`timescale 1ns / 1ps

module tb_top;

  localparam int CH_W     = msid_pkg::CH_W;
  localparam int SAMPLE_W = msid_pkg::SAMPLE_W;
  localparam int TS_W     = msid_pkg::TS_W;
  localparam int CFG_AW   = msid_pkg::CFG_AW;
  localparam int CFG_DW   = msid_pkg::CFG_DW;
  localparam int CHANNELS = msid_pkg::CHANNELS;

  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 73;
  localparam int ROWS          = 17;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_SPIKE} row_check_t;

  typedef struct packed {
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] smp;
    logic [TS_W-1:0]            ts;
    row_check_t                 chk;
    logic [TS_W-1:0]            interval;
  } stim_row_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [TS_W-1:0] interval;
  } spike_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CH_W-1:0]            in_channel = '0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic [TS_W-1:0]            in_timestamp = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [CH_W-1:0]            out_spike_channel;
  logic [TS_W-1:0]            out_interval;
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]          cfg_paddr = '0;
  logic [CFG_DW-1:0]          cfg_pwdata = '0;
  logic [CFG_DW-1:0]          cfg_prdata;
  logic                       cfg_pready;

  // Shadow of the block's thresholds and per-channel state.
  logic signed [SAMPLE_W-1:0] up_thr;
  logic signed [SAMPLE_W-1:0] down_thr;
  bit                         spiking [CHANNELS];
  logic [TS_W-1:0]            last_spike [CHANNELS];

  spike_t          pending_spikes [$];
  int              mismatches = 0;
  int              spikes_seen = 0;
  int              samples_sent = 0;
  bit              calm = 1'b0;
  int              gap_pct = 30;
  int              stall_pct = 30;
  int unsigned     ts_now = 0;

  // Extremes, hysteresis corners, wrapping intervals and alternating bit patterns.
  stim_row_t directed_rows [ROWS] = '{
    '{6'd0,  16'sd16385,  32'd100,        ROW_SPIKE,   32'd100},
    '{6'd0,  16'sd32767,  32'd200,        ROW_QUIET,   32'd0},
    '{6'd0,  16'sd0,      32'd300,        ROW_QUIET,   32'd0},
    '{6'd0,  16'sd16385,  32'd320,        ROW_QUIET,   32'd0},
    '{6'd0,  -16'sd1,     32'd400,        ROW_QUIET,   32'd0},
    '{6'd0,  16'sd16384,  32'd500,        ROW_QUIET,   32'd0},
    '{6'd0,  16'sd20000,  32'd1000,       ROW_SPIKE,   32'd900},
    '{6'd63, 16'sd32767,  32'hFFFF_FFFF,  ROW_SPIKE,   32'hFFFF_FFFF},
    '{6'd63, 16'sh8000,   32'hFFFF_FFFF,  ROW_QUIET,   32'd0},
    '{6'd63, 16'sd16385,  32'd5,          ROW_SPIKE,   32'd6},
    '{6'd0,  16'sh8000,   32'd2000,       ROW_QUIET,   32'd0},
    '{6'd0,  16'sd16385,  32'd900,        ROW_SPIKE,   32'hFFFF_FF9C},
    '{6'd21, 16'sh5555,   32'd0,          ROW_SPIKE,   32'd0},
    '{6'd42, 16'shAAAA,   32'h5555_AAAA,  ROW_QUIET,   32'd0},
    '{6'd42, 16'sd16385,  32'hAAAA_5555,  ROW_SPIKE,   32'hAAAA_5555},
    '{6'd5,  16'sd0,      32'd7,          ROW_PREDICT, 32'd0},
    '{6'd5,  16'sd1234,   32'd8,          ROW_PREDICT, 32'd0}
  };

  multichannel_spike_interval_detector_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_channel        (in_channel),
    .in_sample         (in_sample),
    .in_timestamp      (in_timestamp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_spike_channel (out_spike_channel),
    .out_interval      (out_interval),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Returns 1 when the sample starts a new spike, with the interval since the last one.
  function automatic bit detect_spike(input logic [CH_W-1:0] ch,
                                      input logic signed [SAMPLE_W-1:0] smp,
                                      input logic [TS_W-1:0] ts,
                                      output logic [TS_W-1:0] interval);
    interval = '0;
    if (smp > up_thr) begin
      if (spiking[ch]) return 1'b0;
      spiking[ch] = 1'b1;
      interval = ts - last_spike[ch];
      last_spike[ch] = ts;
      return 1'b1;
    end
    if (smp < down_thr) spiking[ch] = 1'b0;
    return 1'b0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int u;
    int d;
    int v;
    u = up_thr;
    d = down_thr;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = u + 1 + int'($urandom_range(0, 300));
      4, 5, 6:    v = d - 1 - int'($urandom_range(0, 300));
      7: begin
        if (u >= d) v = d + int'($urandom_range(0, u - d));
        else v = int'($urandom_range(0, 65535)) - 32768;
      end
      8:       v = $urandom_range(0, 1) ? u : d;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [TS_W-1:0] next_timestamp();
    // Now and then the clock jumps anywhere, which can also make it go back.
    if ($urandom_range(0, 39) == 0) ts_now = $urandom;
    else ts_now = ts_now + $urandom_range(0, 40);
    return ts_now;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what,
               exp_v, act_v);
  endtask

  // Adds one spike request to the queue of expected results.
  task automatic queue_spike(input logic [CH_W-1:0] ch, input logic [TS_W-1:0] interval);
    spike_t s;
    s.ch       = ch;
    s.interval = interval;
    pending_spikes.insert(pending_spikes.size(), s);
  endtask

  // Holds the request on the input port until the block takes it.
  task automatic offer_sample(input logic [CH_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] smp,
                              input logic [TS_W-1:0] ts);
    bit taken;
    taken = 1'b0;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_channel   <= ch;
    in_sample    <= smp;
    in_timestamp <= ts;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    samples_sent++;
  endtask

  task automatic apb_access();
    bit done;
    done = 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    while (!done) begin
      @(negedge clk);
      done = cfg_pready;
      @(posedge clk);
    end
  endtask

  // Writes one threshold, reads it back, and updates the shadow copy.
  task automatic write_threshold(input logic reg_sel,
                                 input logic signed [SAMPLE_W-1:0] val);
    logic [CFG_DW-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= {{(CFG_DW - SAMPLE_W){val[SAMPLE_W-1]}}, val};
    apb_access();
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    rd = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (rd[SAMPLE_W-1:0] !== val) note_mismatch("threshold readback", 32'(val), rd);
    if (reg_sel == msid_pkg::REG_UP_THRESHOLD) up_thr = val;
    else down_thr = val;
  endtask

  // Lets every expected spike drain, then allows for work still in flight.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_spikes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_sample(input logic [CH_W-1:0] ch,
                            input logic signed [SAMPLE_W-1:0] smp,
                            input logic [TS_W-1:0] ts);
    logic [TS_W-1:0] interval;
    offer_sample(ch, smp, ts);
    if (detect_spike(ch, smp, ts, interval)) queue_spike(ch, interval);
  endtask

  initial begin : stimulus
    logic [TS_W-1:0]            interval;
    logic signed [SAMPLE_W-1:0] up_set [PHASES];
    logic signed [SAMPLE_W-1:0] down_set [PHASES];
    int                         gaps [PHASES];
    int                         stalls [PHASES];
    logic [CH_W-1:0]            ch;
    bit                         hit;

    up_thr   = msid_pkg::UP_THRESHOLD_RESET;
    down_thr = msid_pkg::DOWN_THRESHOLD_RESET;
    for (int i = 0; i < CHANNELS; i++) begin
      spiking[i]    = 1'b0;
      last_spike[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      offer_sample(directed_rows[r].ch, directed_rows[r].smp, directed_rows[r].ts);
      hit = detect_spike(directed_rows[r].ch, directed_rows[r].smp, directed_rows[r].ts,
                         interval);
      case (directed_rows[r].chk)
        ROW_SPIKE:   queue_spike(directed_rows[r].ch, directed_rows[r].interval);
        ROW_PREDICT: if (hit) queue_spike(directed_rows[r].ch, interval);
        default: ;
      endcase
    end
    settle_block();

    // Threshold settings: plain, crossed at the extremes, never firing, crossed near
    // zero, random, and back to the reset values with both sides running flat out.
    up_set   = '{16'sd0, 16'sh8000, 16'sd32767, -16'sd100, 16'sd0,
                 msid_pkg::UP_THRESHOLD_RESET};
    down_set = '{16'sd0, 16'sd32767, 16'sh8000, 16'sd100, 16'sd0,
                 msid_pkg::DOWN_THRESHOLD_RESET};
    up_set[4]   = SAMPLE_W'($urandom);
    down_set[4] = SAMPLE_W'($urandom);
    gaps   = '{20, 50, 10, 0, 35, 0};
    stalls = '{20, 0, 50, 35, 25, 0};

    for (int p = 0; p < PHASES; p++) begin
      write_threshold(msid_pkg::REG_UP_THRESHOLD, up_set[p]);
      write_threshold(msid_pkg::REG_DOWN_THRESHOLD, down_set[p]);
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      calm      = (p == PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        ch = ($urandom_range(0, 9) < 7) ? CH_W'($urandom_range(0, 7))
                                        : CH_W'($urandom_range(0, CHANNELS - 1));
        run_sample(ch, pick_sample(), next_timestamp());
      end
      settle_block();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_spikes.size() != 0)
      note_mismatch("spikes never delivered", 32'd0, 32'(pending_spikes.size()));
    $display("Sent %0d samples over %0d threshold settings; %0d spike requests compared.",
             samples_sent, PHASES + 1, spikes_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 14);
        repeat (hold) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Outputs are stable at the falling edge; a request seen here is taken at the next rise.
  always @(negedge clk) begin : spike_check
    spike_t want;
    if (rst_n && out_valid && out_ready) begin
      spikes_seen++;
      if (pending_spikes.size() == 0) begin
        note_mismatch("unexpected spike, channel", 32'd0, 32'(out_spike_channel));
      end else begin
        want = pending_spikes.pop_front();
        if (out_spike_channel !== want.ch)
          note_mismatch("spike channel", 32'(want.ch), 32'(out_spike_channel));
        if (out_interval !== want.interval)
          note_mismatch("interval", want.interval, out_interval);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
